FILE: rtl/cpa_pkg.sv
package cpa_pkg;

	localparam int CMD_W    = 2;
	localparam int REQ_W    = 11;
	localparam int FIRST_W  = 10;
	localparam int STATUS_W = 2;
	localparam int INDEX_W  = 10;
	localparam int COUNT_W  = 11;
	localparam int PG_W     = 2;

	localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd0;
	localparam logic [CMD_W-1:0] CMD_ALLOC = 2'd1;
	localparam logic [CMD_W-1:0] CMD_FREE  = 2'd2;

	localparam logic [STATUS_W-1:0] ST_DONE    = 2'd0;
	localparam logic [STATUS_W-1:0] ST_NOSPACE = 2'd1;
	localparam logic [STATUS_W-1:0] ST_ZERO    = 2'd2;

	localparam logic [PG_W-1:0] PG_FREE  = 2'd0;
	localparam logic [PG_W-1:0] PG_TAKEN = 2'd1;
	localparam logic [PG_W-1:0] PG_LAST  = 2'd2;

	localparam logic [COUNT_W-1:0] PAGE_COUNT_RST = 11'd1024;

	typedef struct packed {
		logic               valid;
		logic [CMD_W-1:0]   cmd;
		logic [REQ_W-1:0]   request_pages;
		logic [FIRST_W-1:0] first_page;
	} cpa_req_t;

	typedef struct packed {
		logic                valid;
		logic [STATUS_W-1:0] status;
		logic [INDEX_W-1:0]  page_index;
	} cpa_rsp_t;

endpackage

FILE: rtl/contiguous_page_allocator.sv
// Clear writes every page; allocate scans for a free run, then writes the run one page per
// cycle; free walks from first_page at most up to limit.
// Items are handled one at a time; the next item is taken in the cycle after a result enters
// the output register. The result waits there.
// Reset: asynchronous, active low; a clearing pass over all MAX_PAGES pages follows during
// which s_tready is low. page_count resets to 1024.
module contiguous_page_allocator import cpa_pkg::*; #(
	parameter int MAX_PAGES = 1024
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [COUNT_W-1:0] cfg_wdata,  // page_count
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic [23:0]        s_tdata,    // request_pages[10:0], first_page[20:11]
	input  logic [1:0]         s_tuser,    // cmd[1:0]
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [15:0]        m_tdata,    // page_index[9:0]
	output logic [1:0]         m_tuser     // status[1:0]
);

	localparam int AW = $clog2(MAX_PAGES);
	localparam int CW = $clog2(MAX_PAGES + 1);
	localparam int RW = (CW > COUNT_W) ? CW : COUNT_W;

	logic [COUNT_W-1:0]  page_count_q;
	logic [RW-1:0]       pc_ext;
	logic [RW-1:0]       lim_ext;
	logic [CW-1:0]       limit;
	cpa_req_t            req;
	cpa_rsp_t            rsp;
	logic                rsp_ready;
	logic                m_tvalid_q;
	logic [INDEX_W-1:0]  index_q;
	logic [STATUS_W-1:0] status_q;

	logic               ram_we;
	logic [AW-1:0]      ram_waddr;
	logic [PG_W-1:0]    ram_wdata;
	logic               ram_re;
	logic [AW-1:0]      ram_raddr;
	logic [PG_W-1:0]    ram_rdata;

	assign pc_ext  = RW'(page_count_q);
	assign lim_ext = (pc_ext > RW'(MAX_PAGES)) ? RW'(MAX_PAGES) : pc_ext;
	assign limit   = lim_ext[CW-1:0];

	assign req.valid         = s_tvalid;
	assign req.cmd           = s_tuser[CMD_W-1:0];
	assign req.request_pages = s_tdata[REQ_W-1:0];
	assign req.first_page    = s_tdata[REQ_W+FIRST_W-1:REQ_W];

	assign rsp_ready = !m_tvalid_q || m_tready;
	assign m_tvalid  = m_tvalid_q;
	assign m_tdata   = {{(16 - INDEX_W){1'b0}}, index_q};
	assign m_tuser   = status_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			page_count_q <= PAGE_COUNT_RST;
		end else if (cfg_we) begin
			page_count_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
			index_q    <= '0;
			status_q   <= ST_DONE;
		end else if (rsp.valid && rsp_ready) begin
			m_tvalid_q <= 1'b1;
			index_q    <= rsp.page_index;
			status_q   <= rsp.status;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	cpa_seq #(
		.MAX_PAGES(MAX_PAGES)
	) u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.limit    (limit),
		.req      (req),
		.ready    (s_tready),
		.rsp      (rsp),
		.rsp_ready(rsp_ready),
		.ram_we   (ram_we),
		.ram_waddr(ram_waddr),
		.ram_wdata(ram_wdata),
		.ram_re   (ram_re),
		.ram_raddr(ram_raddr),
		.ram_rdata(ram_rdata)
	);

	cpa_ram #(
		.WIDTH(PG_W),
		.DEPTH(MAX_PAGES)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

endmodule

FILE: rtl/cpa_ram.sv
module cpa_ram #(
	parameter int WIDTH = 2,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

FILE: rtl/cpa_seq.sv
module cpa_seq import cpa_pkg::*; #(
	parameter int MAX_PAGES = 1024
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic [$clog2(MAX_PAGES+1)-1:0] limit,
	input  cpa_req_t                     req,
	output logic                         ready,
	output cpa_rsp_t                     rsp,
	input  logic                         rsp_ready,
	output logic                         ram_we,
	output logic [$clog2(MAX_PAGES)-1:0] ram_waddr,
	output logic [PG_W-1:0]              ram_wdata,
	output logic                         ram_re,
	output logic [$clog2(MAX_PAGES)-1:0] ram_raddr,
	input  logic [PG_W-1:0]              ram_rdata
);

	localparam int AW = $clog2(MAX_PAGES);
	localparam int CW = $clog2(MAX_PAGES + 1);
	localparam int RW = (CW > COUNT_W) ? CW : COUNT_W;
	localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_PAGES - 1);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_CLR  = 3'd1;
	localparam logic [2:0] S_SCAN = 3'd2;
	localparam logic [2:0] S_FILL = 3'd3;
	localparam logic [2:0] S_RESP = 3'd4;

	logic [2:0]          state_q;
	logic [CW-1:0]       ptr_q;
	logic [CW-1:0]       chk_q;
	logic [CW-1:0]       cnt_q;
	logic [CW-1:0]       want_q;
	logic                alloc_q;
	logic                clr_rsp_q;
	logic                vld_s1;
	logic [STATUS_W-1:0] status_q;
	logic [INDEX_W-1:0]  index_q;

	logic [RW-1:0] lim_ext;
	logic [RW-1:0] want_ext;
	logic [RW-1:0] first_ext;
	logic [RW-1:0] start_ext;
	logic [CW-1:0] run_inc;
	logic [CW-1:0] start;
	logic          issue;
	logic          pg_free;
	logic          pg_taken;
	logic          last_chk;

	assign lim_ext   = RW'(limit);
	assign want_ext  = RW'(req.request_pages);
	assign first_ext = RW'(req.first_page);
	assign run_inc   = cnt_q + CW'(1);
	assign start     = chk_q + CW'(1) - want_q;
	assign start_ext = RW'(start);
	assign issue     = (state_q == S_SCAN) && (ptr_q < limit);
	assign pg_free   = (ram_rdata == PG_FREE);
	assign pg_taken  = (ram_rdata == PG_TAKEN);
	assign last_chk  = ((chk_q + CW'(1)) == limit);

	assign ready          = (state_q == S_IDLE);
	assign rsp.valid      = (state_q == S_RESP);
	assign rsp.status     = status_q;
	assign rsp.page_index = index_q;

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = ptr_q[AW-1:0];
		ram_wdata = PG_FREE;
		ram_re    = 1'b0;
		ram_raddr = ptr_q[AW-1:0];
		case (state_q)
			S_CLR: begin
				ram_we = 1'b1;
			end
			S_SCAN: begin
				ram_re = issue;
				if (vld_s1 && !alloc_q) begin
					ram_we    = 1'b1;
					ram_waddr = chk_q[AW-1:0];
				end
			end
			S_FILL: begin
				ram_we    = 1'b1;
				ram_wdata = (cnt_q == CW'(1)) ? PG_LAST : PG_TAKEN;
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_CLR;
			ptr_q     <= '0;
			chk_q     <= '0;
			cnt_q     <= '0;
			want_q    <= '0;
			alloc_q   <= 1'b0;
			clr_rsp_q <= 1'b0;
			vld_s1    <= 1'b0;
			status_q  <= ST_DONE;
			index_q   <= '0;
		end else begin
			vld_s1 <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (req.valid) begin
						status_q <= ST_DONE;
						index_q  <= '0;
						cnt_q    <= '0;
						case (req.cmd)
							CMD_CLEAR: begin
								ptr_q     <= '0;
								clr_rsp_q <= 1'b1;
								state_q   <= S_CLR;
							end
							CMD_ALLOC: begin
								if (want_ext == '0) begin
									status_q <= ST_ZERO;
									state_q  <= S_RESP;
								end else if (want_ext > lim_ext) begin
									status_q <= ST_NOSPACE;
									state_q  <= S_RESP;
								end else begin
									alloc_q <= 1'b1;
									want_q  <= want_ext[CW-1:0];
									ptr_q   <= '0;
									state_q <= S_SCAN;
								end
							end
							CMD_FREE: begin
								if (first_ext >= lim_ext) begin
									state_q <= S_RESP;
								end else begin
									alloc_q <= 1'b0;
									ptr_q   <= first_ext[CW-1:0];
									state_q <= S_SCAN;
								end
							end
							default: begin
								state_q <= S_RESP;
							end
						endcase
					end
				end
				S_CLR: begin
					ptr_q <= ptr_q + CW'(1);
					if (ptr_q[AW-1:0] == LAST_ADDR) begin
						state_q <= clr_rsp_q ? S_RESP : S_IDLE;
					end
				end
				S_SCAN: begin
					if (issue) begin
						ptr_q  <= ptr_q + CW'(1);
						chk_q  <= ptr_q;
						vld_s1 <= 1'b1;
					end
					if (vld_s1) begin
						if (alloc_q) begin
							if (pg_free && (run_inc == want_q)) begin
								ptr_q   <= start;
								index_q <= start_ext[INDEX_W-1:0];
								cnt_q   <= want_q;
								vld_s1  <= 1'b0;
								state_q <= S_FILL;
							end else begin
								cnt_q <= pg_free ? run_inc : '0;
							end
						end else if (!pg_taken || last_chk) begin
							vld_s1  <= 1'b0;
							state_q <= S_RESP;
						end
					end else if (!issue) begin
						status_q <= alloc_q ? ST_NOSPACE : ST_DONE;
						state_q  <= S_RESP;
					end
				end
				S_FILL: begin
					ptr_q <= ptr_q + CW'(1);
					cnt_q <= cnt_q - CW'(1);
					if (cnt_q == CW'(1)) begin
						state_q <= S_RESP;
					end
				end
				S_RESP: begin
					clr_rsp_q <= 1'b0;
					if (rsp_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	a_write_busy: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (state_q != S_IDLE) && (state_q != S_RESP))
		else $error("store written while idle");

	a_pipe_scan: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 |-> (state_q == S_SCAN))
		else $error("read data pending outside scan");

	a_fill_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FILL) |->
		(({1'b0, ptr_q} + {1'b0, cnt_q}) <= {1'b0, limit}))
		else $error("fill runs past managed pages");

	a_index_done: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && (index_q != '0)) |-> (status_q == ST_DONE))
		else $error("page index given without success");

	a_accept_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(ready && req.valid) |=> (state_q != S_IDLE))
		else $error("accepted item left no work");

endmodule

FILE: verif/alloc_reply_checker.sv
`timescale 1ns / 1ps

module alloc_reply_checker import cpa_pkg::*; #(
	parameter int MAX_PAGES = 1024
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [COUNT_W-1:0] cfg_wdata,
	input  logic               s_tvalid,
	input  logic               s_tready,
	input  logic [23:0]        s_tdata,
	input  logic [1:0]         s_tuser,
	input  logic               m_tvalid,
	input  logic               m_tready,
	input  logic [15:0]        m_tdata,
	input  logic [1:0]         m_tuser,
	output int                 mismatches,
	output int                 pending
);

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [INDEX_W-1:0]  page_index;
	} alloc_reply_t;

	logic [PG_W-1:0]    page_state [MAX_PAGES];
	logic [COUNT_W-1:0] page_limit;
	alloc_reply_t       expected_replies [$];

	function automatic alloc_reply_t predict_reply(input logic [CMD_W-1:0] cmd,
			input logic [REQ_W-1:0] want, input logic [FIRST_W-1:0] first);
		alloc_reply_t reply;
		int unsigned  active;
		int unsigned  run;
		int unsigned  start;
		int unsigned  i;
		bit           found;
		reply = '0;
		active = (32'(page_limit) > MAX_PAGES) ? MAX_PAGES : 32'(page_limit);
		run = 0;
		start = 0;
		found = 1'b0;
		case (cmd)
		CMD_CLEAR: begin
			for (i = 0; i < MAX_PAGES; i++)
				page_state[i] = PG_FREE;
		end
		CMD_ALLOC: begin
			if (want == '0) begin
				reply.status = ST_ZERO;
			end else begin
				if (want <= active) begin
					for (i = 0; i < active && !found; i++) begin
						if (page_state[i] == PG_FREE) begin
							run++;
							if (run == want) begin
								start = i + 1 - want;
								found = 1'b1;
							end
						end else begin
							run = 0;
						end
					end
				end
				if (found) begin
					for (i = start; i + 1 < start + want; i++)
						page_state[i] = PG_TAKEN;
					page_state[start + want - 1] = PG_LAST;
					reply.page_index = start[INDEX_W-1:0];
				end else begin
					reply.status = ST_NOSPACE;
				end
			end
		end
		CMD_FREE: begin
			if (first < active) begin
				i = 32'(first);
				while (i < active && page_state[i] == PG_TAKEN) begin
					page_state[i] = PG_FREE;
					i++;
				end
				if (i < active)
					page_state[i] = PG_FREE;
			end
		end
		default: ;
		endcase
		return reply;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		alloc_reply_t got;
		alloc_reply_t want;
		if (!arst_n) begin
			foreach (page_state[k])
				page_state[k] = PG_FREE;
			page_limit = PAGE_COUNT_RST;
			expected_replies.delete();
			pending <= 0;
		end else begin
			if (cfg_we)
				page_limit = cfg_wdata;
			if (s_tvalid && s_tready)
				expected_replies.push_back(predict_reply(s_tuser, s_tdata[REQ_W-1:0],
					s_tdata[REQ_W+FIRST_W-1:REQ_W]));
			if (m_tvalid && m_tready) begin
				got.status = m_tuser;
				got.page_index = m_tdata[INDEX_W-1:0];
				if (expected_replies.size() == 0) begin
					$error("unexpected item: status %0d, page_index %0d",
						got.status, got.page_index);
					mismatches++;
				end else begin
					want = expected_replies.pop_front();
					if (got.status !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, got.status);
						mismatches++;
					end
					if (got.page_index !== want.page_index) begin
						$error("page_index: expected %0d, got %0d",
							want.page_index, got.page_index);
						mismatches++;
					end
				end
			end
			pending <= expected_replies.size();
		end
	end

endmodule

FILE: verif/contiguous_page_allocator_test.sv
`timescale 1ns / 1ps

module contiguous_page_allocator_test;
	import cpa_pkg::*;

	localparam int               CYCLE_LIMIT = 12_000_000;
	localparam int               SEG_ITEMS   = 62;
	localparam int               NUM_SEGS    = 9;
	localparam int               PAGES       = 1024;
	localparam logic [CMD_W-1:0] CMD_UNUSED  = 2'd3;

	logic               clk = 1'b0;
	logic               arst_n;
	logic               cfg_we;
	logic [COUNT_W-1:0] cfg_wdata;
	logic               s_tvalid;
	logic               s_tready;
	logic [23:0]        s_tdata;
	logic [1:0]         s_tuser;
	logic               m_tvalid;
	logic               m_tready = 1'b0;
	logic [15:0]        m_tdata;
	logic [1:0]         m_tuser;

	int mismatches;
	int pending;
	int src_idle;
	int sink_idle;
	int sent;
	int allocs_ok;
	int cycle_count;

	logic [COUNT_W-1:0] cur_count;
	logic [FIRST_W-1:0] live_runs [$];
	logic [CMD_W-1:0]   issued_cmds [$];
	logic [COUNT_W-1:0] seg_pages [NUM_SEGS] = '{16, 64, 1024, 1, 40, 2047, 0, 128, 24};

	always #1 clk = ~clk;

	contiguous_page_allocator #(.MAX_PAGES(PAGES)) uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

	alloc_reply_checker #(.MAX_PAGES(PAGES)) reply_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tuser    (m_tuser),
		.mismatches (mismatches),
		.pending    (pending)
	);

	always @(posedge clk)
		m_tready <= ($urandom_range(99) >= sink_idle);

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	// track granted runs so that most frees hit a real run
	always @(posedge clk) begin
		logic [CMD_W-1:0] done_cmd;
		if (arst_n) begin
			if (s_tvalid && s_tready)
				issued_cmds.push_back(s_tuser);
			if (m_tvalid && m_tready && issued_cmds.size() > 0) begin
				done_cmd = issued_cmds.pop_front();
				if (done_cmd == CMD_CLEAR) begin
					live_runs.delete();
				end else if (done_cmd == CMD_ALLOC && m_tuser == ST_DONE) begin
					live_runs.push_back(m_tdata[INDEX_W-1:0]);
					allocs_ok++;
				end
			end
		end
	end

	task automatic send_item(input logic [CMD_W-1:0] c, input logic [REQ_W-1:0] want,
			input logic [FIRST_W-1:0] first);
		while ($urandom_range(99) < src_idle) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {3'b000, first, want};
		s_tuser <= c;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		sent++;
	endtask

	task automatic wait_idle();
		s_tvalid <= 1'b0;
		do
			@(posedge clk);
		while (pending != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_page_count(input logic [COUNT_W-1:0] value);
		wait_idle();
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		cur_count = value;
	endtask

	task automatic random_item();
		int unsigned        lim;
		int unsigned        span;
		int unsigned        pick;
		int unsigned        k;
		logic [CMD_W-1:0]   c;
		logic [REQ_W-1:0]   want;
		logic [FIRST_W-1:0] first;
		lim = (32'(cur_count) > PAGES) ? PAGES : 32'(cur_count);
		span = (lim / 4 > 0) ? lim / 4 : 1;
		want = REQ_W'($urandom_range(2047));
		first = FIRST_W'($urandom_range(1023));
		pick = $urandom_range(99);
		if (pick < 3) begin
			c = CMD_CLEAR;
		end else if (pick < 6) begin
			c = CMD_UNUSED;
		end else if (pick < 55) begin
			c = CMD_ALLOC;
			case ($urandom_range(9))
			0: want = '0;
			1: ;
			2: want = REQ_W'(lim + $urandom_range(2));
			default: want = REQ_W'(1 + $urandom_range(span - 1));
			endcase
		end else begin
			c = CMD_FREE;
			if (live_runs.size() > 0 && $urandom_range(9) < 8) begin
				k = $urandom_range(live_runs.size() - 1);
				first = live_runs[k];
				live_runs.delete(k);
			end else if ($urandom_range(1) == 1 && lim > 0) begin
				first = FIRST_W'($urandom_range(lim - 1));
			end
		end
		send_item(c, want, first);
	endtask

	initial begin
		int seg;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = CMD_CLEAR;
		src_idle = 19;
		sink_idle = 52;
		cur_count = PAGE_COUNT_RST;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		send_item(CMD_ALLOC, 11'd0, 10'd0);
		send_item(CMD_ALLOC, 11'd1, 10'd0);
		send_item(CMD_ALLOC, 11'd3, 10'd0);
		send_item(CMD_ALLOC, 11'd1025, 10'd0);
		send_item(CMD_ALLOC, 11'd2047, 10'd1023);
		send_item(CMD_UNUSED, 11'd2047, 10'd1023);
		send_item(CMD_FREE, 11'd0, 10'd1);
		send_item(CMD_FREE, 11'd2047, 10'd1023);
		send_item(CMD_FREE, 11'd0, 10'd0);
		send_item(CMD_ALLOC, 11'd1024, 10'd0);
		send_item(CMD_ALLOC, 11'd1, 10'd0);
		send_item(CMD_CLEAR, 11'd2047, 10'd1023);
		send_item(CMD_ALLOC, 11'd1020, 10'd0);
		send_item(CMD_ALLOC, 11'd4, 10'd0);
		send_item(CMD_FREE, 11'd0, 10'd1020);
		send_item(CMD_ALLOC, 11'd5, 10'd0);

		// shrink the window so that a free walk runs into the page count
		write_page_count(11'd1000);
		send_item(CMD_FREE, 11'd0, 10'd990);
		send_item(CMD_FREE, 11'd0, 10'd1010);
		send_item(CMD_ALLOC, 11'd10, 10'd0);

		write_page_count(11'd0);
		send_item(CMD_ALLOC, 11'd1, 10'd0);
		send_item(CMD_ALLOC, 11'd0, 10'd0);
		send_item(CMD_FREE, 11'd0, 10'd0);

		write_page_count(11'd2047);
		send_item(CMD_ALLOC, 11'd4, 10'd0);
		send_item(CMD_CLEAR, 11'd0, 10'd0);

		write_page_count(11'd1);
		send_item(CMD_ALLOC, 11'd1, 10'd0);
		send_item(CMD_ALLOC, 11'd1, 10'd0);
		send_item(CMD_FREE, 11'd0, 10'd0);

		for (seg = 0; seg < NUM_SEGS; seg++) begin
			if (seg == 3) begin
				src_idle = 52;
				sink_idle = 19;
			end
			if (seg == 6) begin
				src_idle = 0;
				sink_idle = 0;
			end
			write_page_count(seg_pages[seg]);
			repeat (SEG_ITEMS) random_item();
		end

		wait_idle();
		repeat (20) @(posedge clk);
		$display("Sent %0d commands over %0d page-count settings, %0d runs granted.",
			sent, NUM_SEGS + 4, allocs_ok);
		$display("Covered clear, allocate, free and unused commands with both sides stalling.");
		if (mismatches == 0 && pending == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
